### design/mfia_pkg.sv
// ----------------------------------------------------------------------------
// Multi-format integer ALU package
// Shared types, field widths and operation, format and status codes.
// ----------------------------------------------------------------------------
package mfia_pkg;

    localparam int DEFAULT_MAX_WIDTH = 32;
    localparam int DATA_W            = 32;
    localparam int RESULT_W          = 64;
    localparam int WIDTH_FIELD_W     = 6;
    localparam int CODE_W            = 2;

    // Operation codes
    localparam logic [CODE_W-1:0] OP_ADD = 2'd0;
    localparam logic [CODE_W-1:0] OP_SUB = 2'd1;
    localparam logic [CODE_W-1:0] OP_MUL = 2'd2;
    localparam logic [CODE_W-1:0] OP_DIV = 2'd3;

    // Number formats
    localparam logic [CODE_W-1:0] REP_UNSIGNED = 2'd0;
    localparam logic [CODE_W-1:0] REP_SIGN_MAG = 2'd1;
    localparam logic [CODE_W-1:0] REP_ONES     = 2'd2;
    localparam logic [CODE_W-1:0] REP_TWOS     = 2'd3;

    // Status codes
    localparam logic [CODE_W-1:0] STAT_OK        = 2'd0;
    localparam logic [CODE_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [CODE_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [CODE_W-1:0] STAT_DIV_ZERO  = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0]        op;
        logic [CODE_W-1:0]        representation;
        logic [WIDTH_FIELD_W-1:0] operand_width;
        logic [DATA_W-1:0]        operand_a;
        logic [DATA_W-1:0]        operand_b;
    } alu_cmd_t;

    typedef struct packed {
        logic [RESULT_W-1:0] result;
        logic [DATA_W-1:0]   remainder;
        logic [CODE_W-1:0]   status;
    } alu_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDSUB,
        S_MUL,
        S_DIV,
        S_NEG_Q,
        S_NEG_R,
        S_OUT
    } alu_state_t;

endpackage

### design/multi_format_integer_alu_top.sv
// ----------------------------------------------------------------------------
// Multi-format integer ALU
// Add, subtract, multiply and divide on W-bit operands in unsigned,
// sign-magnitude, ones' complement or two's complement format.
// ----------------------------------------------------------------------------
// One command transaction carries an operation, a number format, the operand
// width W (clamped to 2..MAX_WIDTH) and two raw bit patterns; one response
// transaction returns the W-bit sum, difference or quotient, or the 2W-bit
// product, plus the remainder and a status code (overflow, unsigned underflow,
// divide by zero). On any nonzero status result and remainder are zero. A
// single adder of 2*MAX_WIDTH+1 bits does the add, shift-add, restoring and
// negate steps under a small sequencer, so the block takes one command at a
// time and holds cmd_ready low while it works. Multiply does one shift-add per
// multiplier bit and divide one restoring step per dividend bit; a zero divisor
// skips the steps. The result sits in an output register, so a new command is
// taken while the last response still waits for rsp_ready; the sequencer only
// stalls when a second response is ready before the first has been taken.
module multi_format_integer_alu_top #(
    parameter int MAX_WIDTH = mfia_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mfia_pkg::alu_cmd_t cmd,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mfia_pkg::alu_rsp_t rsp
);

    import mfia_pkg::*;

    localparam int MW = MAX_WIDTH;           // operand datapath width
    localparam int PW = 2 * MAX_WIDTH;       // product width
    localparam int SW = PW + 1;              // shared adder width
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int IW = $clog2(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    alu_state_t        state_reg, state_next;
    logic              rsp_valid_reg, rsp_valid_next;
    alu_rsp_t          rsp_reg, rsp_next;

    logic [CODE_W-1:0] op_reg, op_next;
    logic [CODE_W-1:0] rep_reg, rep_next;
    logic [WW-1:0]     w_reg, w_next;
    logic [MW-1:0]     m_reg, m_next;       // low W ones
    logic [MW-1:0]     top_reg, top_next;   // bit W-1 alone
    logic [MW-1:0]     a_reg, a_next;
    logic [MW-1:0]     b_reg, b_next;
    logic [MW-1:0]     ma_reg, ma_next;     // magnitudes
    logic [MW-1:0]     mb_reg, mb_next;
    logic              sa_reg, sa_next;
    logic              sb_reg, sb_next;
    logic [IW-1:0]     cnt_reg, cnt_next;   // current bit, counts down
    logic [PW-1:0]     prod_reg, prod_next;
    logic [MW-1:0]     q_reg, q_next;       // quotient, or add/sub result
    logic [MW-1:0]     r_reg, r_next;
    logic [CODE_W-1:0] status_reg, status_next;

    // ------------------------------------------------------------------
    // Command decode: clamp width, build masks, extract magnitudes
    // ------------------------------------------------------------------
    logic              cmd_fire;
    logic              rsp_load;
    logic [WW-1:0]     w_in;
    logic [WW-1:0]     sh_in;
    logic [MW-1:0]     m_in, top_in, a_in, b_in, ma_in, mb_in;
    logic              sa_in, sb_in;

    assign cmd_fire = cmd_valid && cmd_ready;

    always_comb
    begin
        if (cmd.operand_width < WIDTH_FIELD_W'(2))
            w_in = WW'(2);
        else if (cmd.operand_width > WIDTH_FIELD_W'(MW))
            w_in = WW'(MW);
        else
            w_in = WW'(cmd.operand_width);
    end

    assign sh_in  = WW'(MW) - w_in;
    assign m_in   = {MW{1'b1}} >> sh_in;
    assign top_in = m_in ^ (m_in >> 1);
    assign a_in   = cmd.operand_a[MW-1:0] & m_in;
    assign b_in   = cmd.operand_b[MW-1:0] & m_in;
    assign sa_in  = |(a_in & top_in);
    assign sb_in  = |(b_in & top_in);

    always_comb
    begin
        case (cmd.representation)
            REP_UNSIGNED:
            begin
                ma_in = a_in;
                mb_in = b_in;
            end
            REP_SIGN_MAG:
            begin
                ma_in = a_in & (m_in >> 1);
                mb_in = b_in & (m_in >> 1);
            end
            REP_ONES:
            begin
                ma_in = sa_in ? (~a_in & m_in) : a_in;
                mb_in = sb_in ? (~b_in & m_in) : b_in;
            end
            default:
            begin
                ma_in = sa_in ? ((MW'(0) - a_in) & m_in) : a_in;
                mb_in = sb_in ? ((MW'(0) - b_in) & m_in) : b_in;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Add/subtract decode
    // ------------------------------------------------------------------
    logic          sub_op;
    logic          sbe;        // effective sign of b after subtract flip
    logic          mag_ge;
    logic [MW-1:0] nb;
    logic [MW-1:0] mm;

    assign sub_op = (op_reg == OP_SUB);
    assign sbe    = sb_reg ^ sub_op;
    assign mag_ge = (ma_reg >= mb_reg);
    assign nb     = ~b_reg & m_reg;
    assign mm     = m_reg >> 1;

    // ------------------------------------------------------------------
    // Shared adder: the add, shift-add, restoring and negate steps go through this one unit
    // ------------------------------------------------------------------
    logic [SW-1:0] alu_x, alu_y, alu_sum;
    logic          alu_cin;
    logic [MW:0]   div_shift;
    logic          div_ge;
    logic          neg_cin;
    logic          neg_pq, neg_r, q_ovf;

    assign div_shift = {r_reg, ma_reg[cnt_reg]};
    assign neg_cin   = (rep_reg == REP_TWOS);
    assign neg_pq    = ((rep_reg == REP_ONES) || (rep_reg == REP_TWOS)) && (sa_reg ^ sb_reg);
    assign neg_r     = ((rep_reg == REP_ONES) && sa_reg && (r_reg != '0))
                    || ((rep_reg == REP_TWOS) && sa_reg);
    assign q_ovf     = (rep_reg == REP_TWOS) && !(sa_reg ^ sb_reg) && (q_reg > mm);

    always_comb
    begin
        alu_x   = '0;
        alu_y   = '0;
        alu_cin = 1'b0;
        case (state_reg)
            S_ADDSUB:
            begin
                case (rep_reg)
                    REP_SIGN_MAG:
                    begin
                        if (sa_reg == sbe)
                        begin
                            alu_x = SW'(ma_reg);
                            alu_y = SW'(mb_reg);
                        end
                        else
                        begin
                            // larger magnitude minus smaller
                            alu_x   = SW'(mag_ge ? ma_reg : mb_reg);
                            alu_y   = SW'(~(mag_ge ? mb_reg : ma_reg) & m_reg);
                            alu_cin = 1'b1;
                        end
                    end
                    REP_ONES:
                    begin
                        alu_x = SW'(a_reg);
                        alu_y = SW'(sub_op ? nb : b_reg);
                    end
                    default:
                    begin
                        alu_x   = SW'(a_reg);
                        alu_y   = SW'(sub_op ? nb : b_reg);
                        alu_cin = sub_op;
                    end
                endcase
            end
            S_MUL:
            begin
                alu_x = SW'({prod_reg[PW-2:0], 1'b0});
                alu_y = mb_reg[cnt_reg] ? SW'(ma_reg) : '0;
            end
            S_DIV:
            begin
                alu_x   = SW'(div_shift);
                alu_y   = ~SW'(mb_reg);
                alu_cin = 1'b1;
            end
            S_NEG_Q:
            begin
                alu_y   = (op_reg == OP_MUL) ? ~SW'(prod_reg) : ~SW'(q_reg);
                alu_cin = neg_cin;
            end
            S_NEG_R:
            begin
                alu_y   = ~SW'(r_reg);
                alu_cin = neg_cin;
            end
            default:
            begin
                alu_x   = '0;
                alu_y   = '0;
                alu_cin = 1'b0;
            end
        endcase
    end

    assign alu_sum = alu_x + alu_y + SW'(alu_cin);
    assign div_ge  = !alu_sum[SW-1];

    // Add/subtract result views
    logic [MW-1:0] sum_lo, eac;
    logic          carry_w, sum_w1, eac_w1;

    assign sum_lo  = alu_sum[MW-1:0] & m_reg;
    assign carry_w = |(alu_sum[MW:0] & {top_reg, 1'b0});
    assign sum_w1  = |(sum_lo & top_reg);
    assign eac     = carry_w ? (sum_lo + MW'(1)) : sum_lo;   // end-around carry
    assign eac_w1  = |(eac & top_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.op)
                        OP_ADD:  state_next = S_ADDSUB;
                        OP_SUB:  state_next = S_ADDSUB;
                        OP_MUL:  state_next = S_MUL;
                        default: state_next = S_DIV;
                    endcase
                end
            end
            S_ADDSUB:
                state_next = S_OUT;
            S_MUL:
            begin
                if (cnt_reg == '0)
                    state_next = S_NEG_Q;
            end
            S_DIV:
            begin
                if (mb_reg == '0)
                    state_next = S_OUT;
                else if (cnt_reg == '0)
                    state_next = S_NEG_Q;
            end
            S_NEG_Q:
                state_next = (op_reg == OP_MUL) ? S_OUT : S_NEG_R;
            S_NEG_R:
                state_next = S_OUT;
            S_OUT:
            begin
                if (rsp_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        cmd_ready      = (state_reg == S_IDLE);
        rsp_load       = (state_reg == S_OUT) && (!rsp_valid_reg || rsp_ready);
        rsp_valid_next = rsp_load || (rsp_valid_reg && !rsp_ready);
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        op_next     = op_reg;
        rep_next    = rep_reg;
        w_next      = w_reg;
        m_next      = m_reg;
        top_next    = top_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next     = cmd.op;
                    rep_next    = cmd.representation;
                    w_next      = w_in;
                    m_next      = m_in;
                    top_next    = top_in;
                    a_next      = a_in;
                    b_next      = b_in;
                    ma_next     = ma_in;
                    mb_next     = mb_in;
                    sa_next     = sa_in;
                    sb_next     = sb_in;
                    cnt_next    = IW'(w_in - WW'(1));
                    prod_next   = '0;
                    q_next      = '0;
                    r_next      = '0;
                    status_next = STAT_OK;
                end
            end
            S_ADDSUB:
            begin
                case (rep_reg)
                    REP_UNSIGNED:
                    begin
                        if (!sub_op)
                        begin
                            if (carry_w)
                                status_next = STAT_OVERFLOW;
                            else
                                q_next = sum_lo;
                        end
                        else
                        begin
                            // carry out of bit W-1 means no borrow
                            if (carry_w)
                                q_next = sum_lo;
                            else
                                status_next = STAT_UNDERFLOW;
                        end
                    end
                    REP_SIGN_MAG:
                    begin
                        if (sa_reg == sbe)
                        begin
                            if (sum_w1)
                                status_next = STAT_OVERFLOW;
                            else
                                q_next = (sa_reg ? top_reg : '0) | sum_lo;
                        end
                        else
                        begin
                            q_next = ((mag_ge ? sa_reg : sbe) ? top_reg : '0) | (sum_lo & mm);
                        end
                    end
                    REP_ONES:
                    begin
                        if ((sa_reg == sbe) && (eac_w1 != sa_reg))
                            status_next = STAT_OVERFLOW;
                        else
                            q_next = eac;
                    end
                    default:
                    begin
                        if ((sa_reg == sbe) && (sum_w1 != sa_reg))
                            status_next = STAT_OVERFLOW;
                        else
                            q_next = sum_lo;
                    end
                endcase
            end
            S_MUL:
            begin
                prod_next = alu_sum[PW-1:0];
                cnt_next  = cnt_reg - IW'(1);
            end
            S_DIV:
            begin
                if (mb_reg == '0)
                    status_next = STAT_DIV_ZERO;
                else
                begin
                    r_next   = div_ge ? alu_sum[MW-1:0] : div_shift[MW-1:0];
                    q_next   = {q_reg[MW-2:0], div_ge};
                    cnt_next = cnt_reg - IW'(1);
                end
            end
            S_NEG_Q:
            begin
                if (op_reg == OP_MUL)
                begin
                    if (neg_pq)
                        prod_next = alu_sum[PW-1:0];
                end
                else if (q_ovf)
                    status_next = STAT_OVERFLOW;
                else if (neg_pq)
                    q_next = alu_sum[MW-1:0];
            end
            S_NEG_R:
            begin
                if (neg_r)
                    r_next = alu_sum[MW-1:0];
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Response formatting: apply width masks and sign-magnitude sign bits
    // ------------------------------------------------------------------
    logic [WW-1:0] sh_w;
    logic [PW-1:0] m2, top2;

    assign sh_w = WW'(MW) - w_reg;
    assign m2   = {PW{1'b1}} >> {sh_w, 1'b0};
    assign top2 = m2 ^ (m2 >> 1);

    always_comb
    begin
        rsp_next = rsp_reg;
        if (rsp_load)
        begin
            rsp_next.result    = '0;
            rsp_next.remainder = '0;
            rsp_next.status    = status_reg;
            if (status_reg == STAT_OK)
            begin
                case (op_reg)
                    OP_MUL:
                    begin
                        rsp_next.result = RESULT_W'((prod_reg & m2)
                            | (((rep_reg == REP_SIGN_MAG) && (sa_reg ^ sb_reg)) ? top2 : '0));
                    end
                    OP_DIV:
                    begin
                        rsp_next.result = RESULT_W'((q_reg & m_reg)
                            | (((rep_reg == REP_SIGN_MAG) && (sa_reg ^ sb_reg)) ? top_reg : '0));
                        rsp_next.remainder = DATA_W'((r_reg & m_reg)
                            | (((rep_reg == REP_SIGN_MAG) && sa_reg) ? top_reg : '0));
                    end
                    default:
                        rsp_next.result = RESULT_W'(q_reg);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        op_reg     <= op_next;
        rep_reg    <= rep_next;
        w_reg      <= w_next;
        m_reg      <= m_next;
        top_reg    <= top_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        cnt_reg    <= cnt_next;
        prod_reg   <= prod_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        status_reg <= status_next;
    end

endmodule

### design/mfia_checker.sv
// ----------------------------------------------------------------------------
// Multi-format integer ALU port checker
// Watches the top-level ports and flags sequencing and response errors.
// ----------------------------------------------------------------------------
module mfia_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_ready,
    input mfia_pkg::alu_cmd_t cmd,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input mfia_pkg::alu_rsp_t rsp
);

    import mfia_pkg::*;

    // Hold a stalled response transaction
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Drop ready right after a command transaction is taken
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while busy");

    // A new response appears only as the sequencer returns to idle
    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> cmd_ready && $past(!cmd_ready))
        else $error("response issued outside the sequencer");

    // Any error status forces a zero result and remainder
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != STAT_OK) |-> (rsp.result == '0) && (rsp.remainder == '0))
        else $error("nonzero payload with error status");

endmodule

bind multi_format_integer_alu_top mfia_checker u_mfia_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

### test/tb.sv
// ----------------------------------------------------------------------------
// Multi-format integer ALU testbench
// Drives command transactions through the valid/ready port, predicts each
// response with an independent model of the four number formats, and checks
// every response field by field. Covers directed corner cases, random traffic
// with and without idle cycles, a long output stall and drain pauses.
// ----------------------------------------------------------------------------
module tb;
    import mfia_pkg::*;

    // Match the default build of the ALU.
    localparam int MAX_W          = DEFAULT_MAX_WIDTH;
    // The longest legal quiet stretch, the long output hold included, stays under
    // this limit; reaching it without any transaction means a hang.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 250;
    // Leave margin for a response still in flight.
    localparam int TAIL_CYCLES    = 40;

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_ready;
    alu_cmd_t cmd;
    logic     rsp_valid;
    logic     rsp_ready;
    alu_rsp_t rsp;

    // Expected responses, oldest first.
    alu_rsp_t pending_results[$];
    alu_rsp_t exp_rsp;
    int       mismatch_count;
    int       idle_cycles;

    // Idle-cycle controls, switched per test.
    bit       sender_gaps;
    bit       receiver_stalls;
    int       hold_req;
    int       hold_cnt;

    multi_format_integer_alu_top #(
        .MAX_WIDTH (MAX_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predict one response from one command.
    // Work in 64 bits throughout: a 2W product needs all of them, and a shift
    // by 64 yields zero, so (1 << 2W) - 1 still gives the full mask at W = 32.
    // ------------------------------------------------------------------------
    function automatic alu_rsp_t predict_alu(input alu_cmd_t c);
        alu_rsp_t    r;
        int unsigned w;
        logic [63:0] m, m2, mm, a, b, ma, mb, s, bb, q, rm, p;
        logic        sa, sb, sbb;
        r = '0;
        w = 32'(c.operand_width);
        if (w < 2)
            w = 2;
        if (w > MAX_W)
            w = MAX_W;
        m  = (64'd1 << w) - 64'd1;
        m2 = (64'd1 << (2 * w)) - 64'd1;
        mm = (64'd1 << (w - 1)) - 64'd1;
        a  = {32'd0, c.operand_a} & m;
        b  = {32'd0, c.operand_b} & m;
        sa = a[w-1];
        sb = b[w-1];
        case (c.representation)
            REP_UNSIGNED:
            begin
                case (c.op)
                    OP_ADD:
                    begin
                        s = a + b;
                        if (s > m)
                            r.status = STAT_OVERFLOW;
                        else
                            r.result = s;
                    end
                    OP_SUB:
                    begin
                        if (a < b)
                            r.status = STAT_UNDERFLOW;
                        else
                            r.result = a - b;
                    end
                    OP_MUL:
                        r.result = a * b;
                    default:
                    begin
                        if (b == 64'd0)
                            r.status = STAT_DIV_ZERO;
                        else
                        begin
                            r.result    = a / b;
                            rm          = a % b;
                            r.remainder = rm[31:0];
                        end
                    end
                endcase
            end
            REP_SIGN_MAG:
            begin
                ma = a & mm;
                mb = b & mm;
                case (c.op)
                    OP_ADD, OP_SUB:
                    begin
                        // Subtract is add with the second operand's sign flipped.
                        sbb = sb ^ (c.op == OP_SUB);
                        if (sa == sbb)
                        begin
                            s = ma + mb;
                            if (s > mm)
                                r.status = STAT_OVERFLOW;
                            else
                                r.result = ({63'd0, sa} << (w - 1)) | s;
                        end
                        else if (ma >= mb)
                            r.result = ({63'd0, sa} << (w - 1)) | (ma - mb);
                        else
                            r.result = ({63'd0, sbb} << (w - 1)) | (mb - ma);
                    end
                    OP_MUL:
                        r.result = ({63'd0, sa ^ sb} << (2 * w - 1)) | (ma * mb);
                    default:
                    begin
                        if (mb == 64'd0)
                            r.status = STAT_DIV_ZERO;
                        else
                        begin
                            r.result    = ({63'd0, sa ^ sb} << (w - 1)) | (ma / mb);
                            rm          = ({63'd0, sa} << (w - 1)) | (ma % mb);
                            r.remainder = rm[31:0];
                        end
                    end
                endcase
            end
            REP_ONES:
            begin
                ma = sa ? (~a & m) : a;
                mb = sb ? (~b & m) : b;
                case (c.op)
                    OP_ADD, OP_SUB:
                    begin
                        bb  = (c.op == OP_SUB) ? (~b & m) : b;
                        sbb = bb[w-1];
                        s   = a + bb;
                        // End-around carry.
                        if (s > m)
                            s = (s & m) + 64'd1;
                        if (sa == sbb && s[w-1] != sa)
                            r.status = STAT_OVERFLOW;
                        else
                            r.result = s;
                    end
                    OP_MUL:
                    begin
                        p = ma * mb;
                        if (sa != sb)
                            p = ~p & m2;
                        r.result = p;
                    end
                    default:
                    begin
                        if (mb == 64'd0)
                            r.status = STAT_DIV_ZERO;
                        else
                        begin
                            q  = ma / mb;
                            rm = ma % mb;
                            if (sa != sb)
                                q = ~q & m;
                            // A zero remainder never turns into negative zero.
                            if (sa && rm != 64'd0)
                                rm = ~rm & m;
                            r.result    = q;
                            r.remainder = rm[31:0];
                        end
                    end
                endcase
            end
            default:
            begin
                ma = sa ? ((64'd0 - a) & m) : a;
                mb = sb ? ((64'd0 - b) & m) : b;
                case (c.op)
                    OP_ADD:
                    begin
                        s = (a + b) & m;
                        if (sa == sb && s[w-1] != sa)
                            r.status = STAT_OVERFLOW;
                        else
                            r.result = s;
                    end
                    OP_SUB:
                    begin
                        s = (a - b) & m;
                        if (sa != sb && s[w-1] != sa)
                            r.status = STAT_OVERFLOW;
                        else
                            r.result = s;
                    end
                    OP_MUL:
                    begin
                        p = ma * mb;
                        if (sa != sb)
                            p = (64'd0 - p) & m2;
                        r.result = p;
                    end
                    default:
                    begin
                        if (mb == 64'd0)
                            r.status = STAT_DIV_ZERO;
                        else
                        begin
                            q  = ma / mb;
                            rm = ma % mb;
                            // Most negative over minus one has no positive result.
                            if (sa == sb && q > mm)
                                r.status = STAT_OVERFLOW;
                            else
                            begin
                                if (sa != sb)
                                    q = (64'd0 - q) & m;
                                if (sa)
                                    rm = (64'd0 - rm) & m;
                                r.result    = q;
                                r.remainder = rm[31:0];
                            end
                        end
                    end
                endcase
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: check responses, record commands, and guard against hangs.
    // Sample at the rising edge; the testbench only drives on the falling one.
    // Check the response before recording a command taken at the same edge,
    // since that response always belongs to an older command.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                // Draw the receiver's next stall now; it applies from the
                // coming falling edge.
                hold_cnt = receiver_stalls ? $urandom_range(0, 17) : 0;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected response %h", $time, rsp);
                end
                else
                begin
                    exp_rsp = pending_results.pop_front();
                    if (rsp.result !== exp_rsp.result)
                    begin
                        mismatch_count++;
                        $display("%0t: result expected %h actual %h",
                                 $time, exp_rsp.result, rsp.result);
                    end
                    if (rsp.remainder !== exp_rsp.remainder)
                    begin
                        mismatch_count++;
                        $display("%0t: remainder expected %h actual %h",
                                 $time, exp_rsp.remainder, rsp.remainder);
                    end
                    if (rsp.status !== exp_rsp.status)
                    begin
                        mismatch_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_rsp.status, rsp.status);
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                pending_results.push_back(predict_alu(cmd));
            // Count cycles in which neither channel moves a transaction.
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: hold rsp_ready low while a stall is counting down.
    // A long hold requested by a test replaces the current stall count.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req > 0)
            begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Every task below starts and returns just after a falling edge.
    // Drop valid only when a gap is drawn, so valid never falls and rises
    // within the same time step.
    // ------------------------------------------------------------------------
    task automatic send_cmd(input alu_cmd_t c);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_op(input logic [CODE_W-1:0] op, input logic [CODE_W-1:0] rep,
                           input logic [WIDTH_FIELD_W-1:0] w,
                           input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        alu_cmd_t c;
        c.op             = op;
        c.representation = rep;
        c.operand_width  = w;
        c.operand_a      = a;
        c.operand_b      = b;
        send_cmd(c);
    endtask

    // Stop offering commands until every expected response has come back.
    // Always advance at least one falling edge so valid is not lowered and
    // raised in the same step.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Mostly legal widths, with some short ones and some out of range.
    function automatic logic [WIDTH_FIELD_W-1:0] rand_width();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 2)
            return WIDTH_FIELD_W'($urandom_range(2, 8));
        else if (k < 8)
            return WIDTH_FIELD_W'($urandom_range(2, MAX_W));
        else
            return WIDTH_FIELD_W'($urandom_range(0, 63));
    endfunction

    // Bias operands toward boundary values of the active width; fill the
    // unused upper bits with noise, which the block must ignore.
    function automatic logic [DATA_W-1:0] rand_operand(input logic [WIDTH_FIELD_W-1:0] wf);
        int unsigned       w;
        logic [DATA_W-1:0] mask, top, v;
        w = 32'(wf);
        if (w < 2)
            w = 2;
        if (w > MAX_W)
            w = MAX_W;
        mask = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
        top  = 32'd1 << (w - 1);
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = mask;
            2:       v = top;
            3:       v = top - 32'd1;
            4:       v = top | 32'd1;
            5:       v = $urandom_range(0, 3);
            default: v = $urandom;
        endcase
        return (v & mask) | ($urandom & ~mask);
    endfunction

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_width_clamp();
        // Widths below two act as two, above the maximum as the maximum.
        send_op(OP_ADD, REP_UNSIGNED, 6'd0,  32'h0000_0003, 32'h0000_0001);
        send_op(OP_MUL, REP_TWOS,     6'd1,  32'h0000_0002, 32'h0000_0003);
        send_op(OP_SUB, REP_SIGN_MAG, 6'd63, 32'hFFFF_FFFF, 32'h0000_0001);
        send_op(OP_DIV, REP_ONES,     6'd33, 32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic test_unsigned();
        send_op(OP_ADD, REP_UNSIGNED, 6'd8,  32'h0000_00FF, 32'h0000_0001);
        send_op(OP_ADD, REP_UNSIGNED, 6'd32, 32'hFFFF_FFFE, 32'h0000_0001);
        send_op(OP_SUB, REP_UNSIGNED, 6'd16, 32'h0000_0001, 32'h0000_0002);
        send_op(OP_SUB, REP_UNSIGNED, 6'd16, 32'h0000_1234, 32'h0000_1234);
        send_op(OP_MUL, REP_UNSIGNED, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_DIV, REP_UNSIGNED, 6'd32, 32'hFFFF_FFFF, 32'h0000_0000);
        send_op(OP_DIV, REP_UNSIGNED, 6'd32, 32'hFFFF_FFFF, 32'h0000_0007);
    endtask

    task automatic test_sign_magnitude();
        // Equal magnitudes with opposite signs keep the first operand's sign.
        send_op(OP_ADD, REP_SIGN_MAG, 6'd8, 32'h0000_0085, 32'h0000_0005);
        send_op(OP_ADD, REP_SIGN_MAG, 6'd8, 32'h0000_007F, 32'h0000_0001);
        send_op(OP_SUB, REP_SIGN_MAG, 6'd8, 32'h0000_0003, 32'h0000_0085);
        // Negative zero times a positive value gives a negative zero product.
        send_op(OP_MUL, REP_SIGN_MAG, 6'd8, 32'h0000_0080, 32'h0000_0005);
        // Negative zero divisor still counts as zero.
        send_op(OP_DIV, REP_SIGN_MAG, 6'd8, 32'h0000_0085, 32'h0000_0080);
        send_op(OP_DIV, REP_SIGN_MAG, 6'd8, 32'h0000_0086, 32'h0000_0003);
    endtask

    task automatic test_ones_complement();
        send_op(OP_ADD, REP_ONES, 6'd8, 32'h0000_00FE, 32'h0000_0003);
        send_op(OP_ADD, REP_ONES, 6'd8, 32'h0000_007F, 32'h0000_0001);
        send_op(OP_MUL, REP_ONES, 6'd8, 32'h0000_00FF, 32'h0000_0005);
        send_op(OP_DIV, REP_ONES, 6'd8, 32'h0000_0007, 32'h0000_00FF);
        send_op(OP_DIV, REP_ONES, 6'd8, 32'h0000_00F8, 32'h0000_0002);
    endtask

    task automatic test_twos_complement();
        send_op(OP_ADD, REP_TWOS, 6'd32, 32'h7FFF_FFFF, 32'h0000_0001);
        send_op(OP_SUB, REP_TWOS, 6'd32, 32'h8000_0000, 32'h0000_0001);
        // Most negative divided by minus one overflows.
        send_op(OP_DIV, REP_TWOS, 6'd32, 32'h8000_0000, 32'hFFFF_FFFF);
        send_op(OP_MUL, REP_TWOS, 6'd32, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_DIV, REP_TWOS, 6'd8,  32'h0000_00F9, 32'h0000_0002);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic; idle cycles on either side are switched per call.
    // ------------------------------------------------------------------------
    task automatic test_random(input int count, input bit gaps, input bit stalls);
        alu_cmd_t c;
        sender_gaps     = gaps;
        receiver_stalls = stalls;
        repeat (count)
        begin
            c.op             = CODE_W'($urandom_range(0, 3));
            c.representation = CODE_W'($urandom_range(0, 3));
            c.operand_width  = rand_width();
            c.operand_a      = rand_operand(c.operand_width);
            c.operand_b      = rand_operand(c.operand_width);
            send_cmd(c);
        end
    endtask

    // Hold the receiver off for a long stretch while commands keep coming,
    // so the output register fills and the block stalls its input.
    task automatic test_output_backpressure();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        hold_req        = LONG_HOLD;
        test_random(12, 1'b0, 1'b0);
        wait_drained();
    endtask

    // Send short bursts and let the pipeline empty between them.
    task automatic test_drain_pauses();
        repeat (8)
        begin
            test_random(3, 1'b0, 1'b1);
            wait_drained();
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cmd_valid       = 1'b0;
        cmd             = '0;
        rsp_ready       = 1'b0;
        mismatch_count  = 0;
        idle_cycles     = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_req        = 0;
        hold_cnt        = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_width_clamp();
        test_unsigned();
        test_sign_magnitude();
        test_ones_complement();
        test_twos_complement();
        test_random(600, 1'b1, 1'b1);
        test_output_backpressure();
        test_random(350, 1'b0, 1'b0);
        test_drain_pauses();
        test_random(350, 1'b1, 1'b0);
        test_random(350, 1'b0, 1'b1);

        // Wait for the last responses, then watch for any stray one.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
